// File: design/sssb_pkg.sv
// ----------------------------------------------------------------------------
// sssb_pkg
// Types, constants and the symbol decoder of the seven-segment scan and
// blink unit.
// ----------------------------------------------------------------------------
package sssb_pkg;

  localparam int DIGITS_DEFAULT = 8;
  localparam int POS_W          = 3;
  localparam int SYM_W          = 8;
  localparam int SEG_W          = 8;
  localparam int IDX_W          = 4;
  localparam int BUF_DEPTH      = 9;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 3;

  localparam logic [IDX_W-1:0] SPARE_ENTRY = 4'd8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_ENABLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_POSITION = 1'b1;

  // Item kinds
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] entry_index;
    logic [SYM_W-1:0] symbol;
    logic             scan_tick;
    logic             blink_tick;
  } sssb_in_t;

  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic [7:0]       digit_select_n;
    logic [POS_W-1:0] digit_shown;
  } sssb_out_t;

  typedef struct packed {
    logic             known;
    logic [SEG_W-1:0] pattern;
  } sssb_decode_t;

  // Map a symbol code to its segment pattern; unknown codes are flagged
  function automatic sssb_decode_t sym_decode(input logic [SYM_W-1:0] s);
    sssb_decode_t d;
    d.known = 1'b1;
    case (s)
      8'd0:  d.pattern = 8'h3f;
      8'd1:  d.pattern = 8'h06;
      8'd2:  d.pattern = 8'h5b;
      8'd3:  d.pattern = 8'h4f;
      8'd4:  d.pattern = 8'h66;
      8'd5:  d.pattern = 8'h6d;
      8'd6:  d.pattern = 8'h7d;
      8'd7:  d.pattern = 8'h07;
      8'd8:  d.pattern = 8'h7f;
      8'd9:  d.pattern = 8'h6f;
      8'd10: d.pattern = 8'h77;
      8'd11: d.pattern = 8'h7c;
      8'd12: d.pattern = 8'h39;
      8'd13: d.pattern = 8'h5e;
      8'd14: d.pattern = 8'h79;
      8'd15: d.pattern = 8'h71;
      // decimal digits with the dot lit
      8'd20: d.pattern = 8'hbf;
      8'd21: d.pattern = 8'h86;
      8'd22: d.pattern = 8'hdb;
      8'd23: d.pattern = 8'hcf;
      8'd24: d.pattern = 8'he6;
      8'd25: d.pattern = 8'hed;
      8'd26: d.pattern = 8'hfd;
      8'd27: d.pattern = 8'h87;
      8'd28: d.pattern = 8'hff;
      8'd29: d.pattern = 8'hef;
      // ASCII marks and letters
      8'h2d: d.pattern = 8'h40; // '-'
      8'h2e: d.pattern = 8'h63; // '.'
      8'h52: d.pattern = 8'h72; // 'R'
      8'h20: d.pattern = 8'h00; // space
      8'h48: d.pattern = 8'h76; // 'H'
      8'h49: d.pattern = 8'h30; // 'I'
      8'h4c: d.pattern = 8'h38; // 'L'
      8'h4d: d.pattern = 8'h33; // 'M'
      8'h6d: d.pattern = 8'h27; // 'm'
      8'h4e: d.pattern = 8'h37; // 'N'
      8'h54: d.pattern = 8'h31; // 'T'
      8'h55: d.pattern = 8'h3e; // 'U'
      8'h57: d.pattern = 8'h3c; // 'W'
      8'h77: d.pattern = 8'h1e; // 'w'
      8'h6f: d.pattern = 8'h5c; // 'o'
      default: begin
        d.known   = 1'b0;
        d.pattern = '0;
      end
    endcase
    return d;
  endfunction

endpackage

// File: design/seven_segment_scan_blink_unit.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_blink_unit
// Multiplexed seven-segment driver with a nine-entry symbol buffer and
// single-digit blinking.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : items from the host. A write item (func 0) stores a symbol in
//            buffer entry 0..8; a tick item (func 1) may carry a scan tick
//            and/or a blink tick. Transfer when in_valid is high and in_stall
//            is low.
//   out_*  : one result per scan tick: latched segments, active-low digit
//            select and the digit position shown. Transfer when out_valid is
//            high and out_stall is low.
//   cfg_*  : register writes (blink enable, blink position), always ready.
//            Write only while the block is idle.
// Timing: an item is taken every cycle while in_stall is low. A scan result
//   goes to the output register, or the skid if it stalls; state updates
//   happen in the same edge that takes the item, so items follow back to back.
// Stall: a stalled output holds; one more result fits in a skid register,
//   after which in_stall rises until the receiver takes a result.
// Reset: buffer entries, scan position, pending blink and segment latch
//   clear; blink is disabled with position 7; no result is pending.
// ----------------------------------------------------------------------------
module seven_segment_scan_blink_unit #(
  parameter int DIGITS = sssb_pkg::DIGITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sssb_pkg::sssb_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sssb_pkg::sssb_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sssb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sssb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sssb_pkg::*;

  // Configuration registers
  logic             blink_en_r;
  logic [POS_W-1:0] blink_pos_r;

  // Display state
  logic [SYM_W-1:0] sym_buf_r   [BUF_DEPTH];
  logic [SYM_W-1:0] sym_buf_nxt [BUF_DEPTH];
  logic [POS_W-1:0] scan_pos_r, scan_pos_nxt;
  logic             pending_r, pending_nxt;
  logic [SEG_W-1:0] seg_r, seg_nxt;

  // Output register and skid
  logic      out_valid_r, out_valid_nxt;
  sssb_out_t out_data_r, out_data_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  sssb_out_t skid_data_r, skid_data_nxt;

  logic         in_take;
  logic         out_take;
  logic         is_tick;
  logic         scan_go;
  logic         pending_eff;
  logic         do_swap;
  logic [SYM_W-1:0] scan_sym;
  logic [SYM_W-1:0] blink_sym;
  sssb_decode_t dec;
  sssb_out_t    res;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_tick     = in_take && (in_data.func == FUNC_TICK);
  assign scan_go     = is_tick && in_data.scan_tick;
  assign pending_eff = pending_r || (is_tick && in_data.blink_tick);
  assign do_swap     = scan_go && blink_en_r && pending_eff;

  // Read the symbol under scan and the one at the blink position
  assign scan_sym  = sym_buf_r[scan_pos_r];
  assign blink_sym = sym_buf_r[blink_pos_r];
  assign dec       = sym_decode(scan_sym);

  // Decode, form the result and advance the scan
  always_comb begin
    seg_nxt      = seg_r;
    scan_pos_nxt = scan_pos_r;
    pending_nxt  = pending_eff;
    if (scan_go) begin
      if (dec.known) begin
        seg_nxt = dec.pattern;
      end
      if (scan_pos_r == POS_W'(DIGITS - 1)) begin
        scan_pos_nxt = '0;
      end else begin
        scan_pos_nxt = scan_pos_r + POS_W'(1);
      end
      if (do_swap) begin
        pending_nxt = 1'b0;
      end
    end
    res.segments       = seg_nxt;
    res.digit_select_n = ~(8'h80 >> scan_pos_r);
    res.digit_shown    = scan_pos_r;
  end

  // Buffer writes and the blink swap with the spare entry
  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      sym_buf_nxt[i] = sym_buf_r[i];
      if (in_take && (in_data.func == FUNC_WRITE) &&
          (in_data.entry_index == IDX_W'(i))) begin
        sym_buf_nxt[i] = in_data.symbol;
      end
      if (do_swap && (IDX_W'(i) == {1'b0, blink_pos_r})) begin
        sym_buf_nxt[i] = sym_buf_r[SPARE_ENTRY];
      end
    end
    if (do_swap) begin
      sym_buf_nxt[SPARE_ENTRY] = blink_sym;
    end
  end

  // Steer results into the output register or the skid
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (scan_go) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and display state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_en_r   <= 1'b0;
      blink_pos_r  <= 3'd7;
      scan_pos_r   <= '0;
      pending_r    <= 1'b0;
      seg_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      for (int i = 0; i < BUF_DEPTH; i++) begin
        sym_buf_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BLINK_ENABLE:   blink_en_r  <= cfg_data[0];
          REG_BLINK_POSITION: blink_pos_r <= cfg_data[POS_W-1:0];
          default: ;
        endcase
      end
      scan_pos_r   <= scan_pos_nxt;
      pending_r    <= pending_nxt;
      seg_r        <= seg_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      for (int i = 0; i < BUF_DEPTH; i++) begin
        sym_buf_r[i] <= sym_buf_nxt[i];
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

// File: design/sssb_checker.sv
// ----------------------------------------------------------------------------
// sssb_checker
// Port-level checks for the seven-segment scan and blink unit.
// ----------------------------------------------------------------------------
module sssb_checker #(
  parameter int DIGITS = sssb_pkg::DIGITS_DEFAULT
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input sssb_pkg::sssb_out_t             out_data
);
  import sssb_pkg::*;

  // Exactly one digit is enabled in every result
  a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones(~out_data.digit_select_n) == 1))
    else $error("digit select is not one-hot low");

  // The enabled digit matches the position reported
  a_select_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.digit_select_n[3'd7 - out_data.digit_shown] == 1'b0))
    else $error("digit select disagrees with digit shown");

  // Scan position stays within the scanned digits
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_data.digit_shown) < DIGITS))
    else $error("digit shown beyond scanned digits");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind seven_segment_scan_blink_unit sssb_checker #(.DIGITS(DIGITS)) u_sssb_checker (.*);

// File: bench/scan_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_result_checker
// Watches the item, result and register channels of the seven-segment scan
// and blink unit, keeps its own copy of the symbol buffer, scan position,
// pending blink and segment latch, and compares every result taken from the
// block with the oldest predicted scan.
// ----------------------------------------------------------------------------
module scan_result_checker #(
  parameter int DIGITS = sssb_pkg::DIGITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  sssb_pkg::sssb_in_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  sssb_pkg::sssb_out_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sssb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sssb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              failures,
  output int                              outstanding
);
  import sssb_pkg::*;

  // Glyphs of the hex digits, digit 0 in the low byte
  localparam logic [16*8-1:0] HEX_GLYPHS = {
    8'h71, 8'h79, 8'h5e, 8'h39, 8'h7c, 8'h77, 8'h6f, 8'h7f,
    8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
  };

  logic [SYM_W-1:0] sym_store [BUF_DEPTH];
  logic [POS_W-1:0] scan_pos;
  logic             blink_due;
  logic [SEG_W-1:0] seg_hold;
  logic             blink_on;
  logic [POS_W-1:0] blink_at;
  sssb_out_t        scans_due[$];
  int               fail_count;

  // Return 1 and the glyph for a known symbol, 0 for an unknown one
  function automatic logic glyph_for(input logic [SYM_W-1:0] s, output logic [SEG_W-1:0] g);
    logic ok;
    ok = 1'b1;
    g  = '0;
    if (s <= 8'd15) begin
      g = HEX_GLYPHS[int'(s)*8 +: 8];
    end else if (s >= 8'd20 && s <= 8'd29) begin
      // decimal digit with the dot lit
      g = HEX_GLYPHS[(int'(s) - 20)*8 +: 8] | 8'h80;
    end else begin
      case (s)
        "-":     g = 8'h40;
        ".":     g = 8'h63;
        "R":     g = 8'h72;
        " ":     g = 8'h00;
        "H":     g = 8'h76;
        "I":     g = 8'h30;
        "L":     g = 8'h38;
        "M":     g = 8'h33;
        "m":     g = 8'h27;
        "N":     g = 8'h37;
        "T":     g = 8'h31;
        "U":     g = 8'h3e;
        "W":     g = 8'h3c;
        "w":     g = 8'h1e;
        "o":     g = 8'h5c;
        default: ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

  // Advance the local copy by one accepted item
  task automatic apply_item(input sssb_in_t item);
    logic [SEG_W-1:0] g;
    logic [POS_W-1:0] p;
    logic [SYM_W-1:0] swap;
    sssb_out_t        scan;
    if (item.func == FUNC_WRITE) begin
      // out-of-range entries are dropped
      if (item.entry_index < BUF_DEPTH) sym_store[item.entry_index] = item.symbol;
    end else begin
      if (item.blink_tick) blink_due = 1'b1;
      if (item.scan_tick) begin
        p = scan_pos;
        // an unknown symbol leaves the latch as it was
        if (glyph_for(sym_store[p], g)) seg_hold = g;
        scan.segments       = seg_hold;
        scan.digit_select_n = ~(8'h80 >> p);
        scan.digit_shown    = p;
        scans_due.push_back(scan);
        scan_pos = (p == POS_W'(DIGITS - 1)) ? '0 : p + 1'b1;
        // swap the blinking digit with the spare entry after the scan
        if (blink_on && blink_due) begin
          swap                   = sym_store[blink_at];
          sym_store[blink_at]    = sym_store[SPARE_ENTRY];
          sym_store[SPARE_ENTRY] = swap;
          blink_due              = 1'b0;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    sssb_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < BUF_DEPTH; i++) sym_store[i] = '0;
      scan_pos   = '0;
      blink_due  = 1'b0;
      seg_hold   = '0;
      blink_on   = 1'b0;
      blink_at   = POS_W'(7);
      fail_count = 0;
      scans_due.delete();
    end else begin
      // compare a taken result with the oldest predicted scan
      if (out_valid && !out_stall) begin
        if (scans_due.size() == 0) begin
          $error("result transfer with no scan waiting: %h", out_data);
          fail_count++;
        end else begin
          want = scans_due.pop_front();
          if (out_data.segments !== want.segments) begin
            $error("segments: expected %h, got %h", want.segments, out_data.segments);
            fail_count++;
          end
          if (out_data.digit_select_n !== want.digit_select_n) begin
            $error("digit_select_n: expected %h, got %h",
                   want.digit_select_n, out_data.digit_select_n);
            fail_count++;
          end
          if (out_data.digit_shown !== want.digit_shown) begin
            $error("digit_shown: expected %0d, got %0d", want.digit_shown,
                   out_data.digit_shown);
            fail_count++;
          end
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BLINK_ENABLE:   blink_on = cfg_data[0];
          REG_BLINK_POSITION: blink_at = cfg_data[POS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) apply_item(in_data);
    end
    failures    <= fail_count;
    outstanding <= scans_due.size();
  end

endmodule

// File: bench/seven_segment_scan_blink_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_blink_unit_test
// Drives buffer writes and scan/blink ticks into the display driver under
// random sender gaps and receiver stalls, across several blink settings, and
// reports the verdict from the failure count of the result checker.
// ----------------------------------------------------------------------------
module seven_segment_scan_blink_unit_test;
  import sssb_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 250;
  // ASCII marks and letters that have a glyph
  localparam logic [15*8-1:0] MARKS = "-.R HILMmNTUWwo";

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  sssb_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  sssb_out_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    failures;
  int                    outstanding;
  int                    cycle_count;
  int                    hold_left;
  logic                  gaps_on;
  logic                  stalls_on;

  seven_segment_scan_blink_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  scan_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [SYM_W-1:0] random_symbol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return SYM_W'($urandom_range(0, 15));
    if (r < 55) return SYM_W'($urandom_range(20, 29));
    if (r < 80) return MARKS[$urandom_range(0, 14)*8 +: 8];
    if (r < 88) return SYM_W'($urandom_range(16, 19));
    return SYM_W'($urandom_range(0, 255));
  endfunction

  function automatic sssb_in_t make_item(input logic f, input int idx, input int sym,
                                         input logic scan, input logic blink);
    sssb_in_t it;
    it.func        = f;
    it.entry_index = IDX_W'(idx);
    it.symbol      = SYM_W'(sym);
    it.scan_tick   = scan;
    it.blink_tick  = blink;
    return it;
  endfunction

  function automatic sssb_in_t random_item();
    sssb_in_t it;
    it.func        = ($urandom_range(0, 99) < 45) ? FUNC_WRITE : FUNC_TICK;
    // mostly valid entries, a few beyond the spare
    it.entry_index = ($urandom_range(0, 99) < 90) ? IDX_W'($urandom_range(0, 8))
                                                  : IDX_W'($urandom_range(0, 15));
    it.symbol      = random_symbol();
    it.scan_tick   = ($urandom_range(0, 99) < 80);
    it.blink_tick  = ($urandom_range(0, 99) < 20);
    return it;
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(input sssb_in_t item);
    int gap;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = gaps_on ? idle_length() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every predicted scan has come out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both blink registers back to back
  task automatic set_blink(input logic en, input logic [POS_W-1:0] pos);
    cfg_valid <= 1'b1;
    cfg_index <= REG_BLINK_ENABLE;
    cfg_data  <= CFG_DATA_W'(en);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_BLINK_POSITION;
    cfg_data  <= CFG_DATA_W'(pos);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (stalls_on && $urandom_range(0, 99) < 30) begin
      out_stall <= 1'b1;
      hold_left <= idle_length();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Run limit
  always @(posedge clk) begin
    if (!rst_n) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
        $display("seven_segment_scan_blink_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    gaps_on     = 1'b0;
    stalls_on   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Scan the cleared buffer once
    send_item(make_item(FUNC_TICK, 0, 0, 1'b1, 1'b0));
    // Fill every entry: hex and dotted extremes, unknown codes, marks
    send_item(make_item(FUNC_WRITE, 0, 15, 1'b0, 1'b0));
    send_item(make_item(FUNC_WRITE, 1, 16, 1'b0, 1'b0));
    send_item(make_item(FUNC_WRITE, 2, 29, 1'b0, 1'b0));
    send_item(make_item(FUNC_WRITE, 3, 255, 1'b0, 1'b0));
    send_item(make_item(FUNC_WRITE, 4, "-", 1'b0, 1'b0));
    send_item(make_item(FUNC_WRITE, 5, "o", 1'b0, 1'b0));
    send_item(make_item(FUNC_WRITE, 6, 20, 1'b0, 1'b0));
    send_item(make_item(FUNC_WRITE, 7, " ", 1'b0, 1'b0));
    send_item(make_item(FUNC_WRITE, 8, "H", 1'b0, 1'b0));
    // Out-of-range writes, tick bits set on a write: all dropped
    send_item(make_item(FUNC_WRITE, 15, 8'hff, 1'b1, 1'b1));
    send_item(make_item(FUNC_WRITE, 9, 8'h55, 1'b0, 1'b0));
    // Blink event while disabled, then an empty tick
    send_item(make_item(FUNC_TICK, 0, 0, 1'b0, 1'b1));
    send_item(make_item(FUNC_TICK, 15, 8'hff, 1'b0, 1'b0));
    // One full sweep, back to position 1
    for (int i = 0; i < 8; i++) send_item(make_item(FUNC_TICK, 0, 0, 1'b1, 1'b0));
    wait_for_results();

    // Enable blink on entry 0: the latched event swaps after the next scan
    set_blink(1'b1, 3'd0);
    send_item(make_item(FUNC_TICK, 0, 0, 1'b1, 1'b0));
    send_item(make_item(FUNC_TICK, 0, 0, 1'b1, 1'b1));
    send_item(make_item(FUNC_TICK, 0, 0, 1'b1, 1'b0));
    wait_for_results();

    // Random phases under different blink settings and idling
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       set_blink(1'b1, 3'd7);
        1:       set_blink(1'b0, 3'd0);
        2:       set_blink(1'b1, 3'd3);
        3:       set_blink(1'b1, POS_W'($urandom_range(0, 7)));
        default: set_blink(1'b1, 3'd0);
      endcase
      gaps_on   <= (ph % 3 != 2);
      stalls_on <= (ph % 3 != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_item());
        if ($urandom_range(0, 199) == 0) wait_for_results();
      end
      wait_for_results();
    end

    if (failures == 0) begin
      $display("seven_segment_scan_blink_unit: match");
    end else begin
      $display("seven_segment_scan_blink_unit: mismatch");
    end
    $finish;
  end

endmodule
